// File: rtl/dqb_pkg.sv
`timescale 1ns / 1ps
package dqb_pkg;

  localparam int MAX_LABEL_DEF = 63;
  localparam int HDR_LEN = 12;
  localparam int TAIL_LEN = 5;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LW = $clog2(OUT_DEPTH) + 1;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic REG_ID_LOW_FIRST = 1'b0;
  localparam logic REG_RECURSION = 1'b1;

  typedef struct packed {
    logic header;
    logic [7:0] id_first;
    logic [7:0] id_second;
    logic rd;
    logic flush;
    logic bank;
    logic tail;
    logic overflow;
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic second_valid;
    logic run_last;
    logic packet_end;
    logic label_overflow;
  } result_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic from_mem;
    logic [7:0] value;
  } byte_src_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [7:0] id_first,
                                          input logic [7:0] id_second, input logic rd);
    logic [7:0] b;
    case (idx)
      4'd0: b = id_first;
      4'd1: b = id_second;
      4'd2: b = {7'b0, rd};
      4'd5: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd2, 3'd4: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/dqb_fifo.sv
`timescale 1ns / 1ps
module dqb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic full,
  output logic empty,
  output logic [$clog2(DEPTH):0] level
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic do_wr;
  logic do_rd;

  assign full = level == (AW + 1)'(DEPTH);
  assign empty = level == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = store[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      level <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + (AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - (AW + 1)'(1);
      end
    end
  end
endmodule

// File: rtl/dqb_front.sv
`timescale 1ns / 1ps
module dqb_front #(
  parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF,
  parameter int LW = $clog2(MAX_LABEL + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [7:0] name_char,
  input  logic name_last,
  output logic full,
  input  logic id_low_first,
  input  logic recursion_desired,
  input  logic cmd_full,
  output logic cmd_push,
  output dqb_pkg::cmd_t cmd,
  output logic [LW-1:0] cmd_len,
  output logic mem_we,
  output logic [LW:0] mem_waddr,
  output logic [7:0] mem_wdata,
  input  dqb_pkg::rel_t release_bank
);
  import dqb_pkg::*;

  logic packet_open;
  logic [LW-1:0] label_length;
  logic overflow_seen;
  logic [15:0] query_id;
  logic cur_bank;
  logic [1:0] busy;

  logic accept;
  logic is_dot;
  logic [LW-1:0] len0;
  logic [LW-1:0] len1;
  logic ov0;
  logic ov1;
  logic store_char;
  logic flush;
  logic [15:0] id_next;

  assign full = cmd_full || busy[cur_bank];
  assign accept = push && !full;

  always_comb begin
    is_dot = name_char == DOT_CHAR;
    len0 = packet_open ? label_length : '0;
    ov0 = packet_open && overflow_seen;
    id_next = query_id + 16'd1;
    store_char = !is_dot && (len0 < LW'(MAX_LABEL));
    len1 = store_char ? len0 + LW'(1) : len0;
    ov1 = ov0 || (!is_dot && !store_char);
    flush = (is_dot || name_last) && (len1 != '0);

    cmd.header = !packet_open;
    cmd.id_first = id_low_first ? id_next[7:0] : id_next[15:8];
    cmd.id_second = id_low_first ? id_next[15:8] : id_next[7:0];
    cmd.rd = recursion_desired;
    cmd.flush = flush;
    cmd.bank = cur_bank;
    cmd.tail = name_last;
    cmd.overflow = ov1;
    cmd_len = len1;
    cmd_push = accept && (!packet_open || flush || name_last);

    mem_we = accept && store_char;
    mem_waddr = {cur_bank, len0};
    mem_wdata = name_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      label_length <= '0;
      overflow_seen <= 1'b0;
      query_id <= '0;
      cur_bank <= 1'b0;
      busy <= '0;
    end else begin
      if (release_bank.valid) begin
        busy[release_bank.bank] <= 1'b0;
      end
      if (accept) begin
        packet_open <= !name_last;
        label_length <= flush ? '0 : len1;
        overflow_seen <= ov1;
        if (!packet_open) begin
          query_id <= id_next;
        end
        if (flush) begin
          cur_bank <= ~cur_bank;
          busy[cur_bank] <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/dqb_back.sv
`timescale 1ns / 1ps
module dqb_back #(
  parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF,
  parameter int LW = $clog2(MAX_LABEL + 1),
  parameter int PW = $clog2(MAX_LABEL + 19)
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  dqb_pkg::cmd_t cmd,
  input  logic [LW-1:0] cmd_len,
  output logic cmd_pop,
  input  logic mem_we,
  input  logic [LW:0] mem_waddr,
  input  logic [7:0] mem_wdata,
  output dqb_pkg::rel_t release_bank,
  input  logic [dqb_pkg::OUT_LW-1:0] out_level,
  output logic out_push,
  output dqb_pkg::result_t out_data
);
  import dqb_pkg::*;

  localparam int MEM_DEPTH = 2 ** (LW + 1);

  logic [7:0] label_mem [MEM_DEPTH];

  logic [PW-1:0] pos;
  logic [PW-1:0] pos1;
  logic [PW-1:0] hl;
  logic [PW-1:0] fl;
  logic [PW-1:0] total;
  logic [LW-1:0] addr0;
  logic [LW-1:0] addr1;
  byte_src_t src0;
  byte_src_t src1;
  logic two;
  logic fin;
  logic issue;
  logic [OUT_LW:0] occ;

  logic s2_valid;
  byte_src_t s2_src0;
  byte_src_t s2_src1;
  logic s2_two;
  logic s2_run_last;
  logic s2_packet_end;
  logic s2_overflow;
  logic [7:0] rd0;
  logic [7:0] rd1;

  function automatic byte_src_t pick(input logic [PW-1:0] p_pos, input logic [PW-1:0] p_hl,
                                     input logic [PW-1:0] p_fl, input cmd_t p_cmd,
                                     input logic [LW-1:0] p_len);
    byte_src_t s;
    logic [PW-1:0] p;
    logic [PW-1:0] q;
    p = p_pos - p_hl;
    q = p - p_fl;
    s.from_mem = 1'b0;
    s.value = 8'h00;
    if (p_pos < p_hl) begin
      s.value = hdr_byte(p_pos[3:0], p_cmd.id_first, p_cmd.id_second, p_cmd.rd);
    end else if (p < p_fl) begin
      if (p == '0) begin
        s.value = 8'(p_len);
      end else begin
        s.from_mem = 1'b1;
      end
    end else begin
      s.value = tail_byte(q[2:0]);
    end
    return s;
  endfunction

  always_comb begin
    hl = cmd.header ? PW'(HDR_LEN) : '0;
    fl = cmd.flush ? PW'(cmd_len) + PW'(1) : '0;
    total = hl + fl + (cmd.tail ? PW'(TAIL_LEN) : '0);
    pos1 = pos + PW'(1);
    addr0 = LW'(pos - hl - PW'(1));
    addr1 = LW'(pos1 - hl - PW'(1));
    src0 = pick(pos, hl, fl, cmd, cmd_len);
    src1 = pick(pos1, hl, fl, cmd, cmd_len);
    two = pos1 < total;
    fin = ({1'b0, pos} + (PW + 1)'(2)) >= {1'b0, total};
    occ = {1'b0, out_level} + {{OUT_LW{1'b0}}, s2_valid};
    issue = cmd_valid && (occ < (OUT_LW + 1)'(OUT_DEPTH));
    cmd_pop = issue && fin;
    release_bank.valid = issue && fin && cmd.flush;
    release_bank.bank = cmd.bank;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      label_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd0 <= label_mem[{cmd.bank, addr0}];
      rd1 <= label_mem[{cmd.bank, addr1}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_src0 <= src0;
      s2_src1 <= src1;
      s2_two <= two;
      s2_run_last <= fin;
      s2_packet_end <= fin && cmd.tail;
      s2_overflow <= cmd.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue;
      if (issue) begin
        pos <= fin ? '0 : pos + PW'(2);
      end
    end
  end

  always_comb begin
    out_push = s2_valid;
    out_data.byte_first = s2_src0.from_mem ? rd0 : s2_src0.value;
    out_data.byte_second = s2_two ? (s2_src1.from_mem ? rd1 : s2_src1.value) : 8'h00;
    out_data.second_valid = s2_two;
    out_data.run_last = s2_run_last;
    out_data.packet_end = s2_packet_end;
    out_data.label_overflow = s2_overflow;
  end
endmodule

// File: rtl/dns_query_builder.sv
// An item's first result passes the command queue, a back register stage and the result queue.
// A character that only extends a label is taken every cycle unless full; the back sequencer
// emits two packet bytes per cycle while the result queue has room; up to 41 results per item.
// The label buffer has two banks; input stalls while the bank to be filled still drains.
// Reset is synchronous: queues empty, query id zero, both configuration bits one.
// The label buffer needs no clearing after reset.
`timescale 1ns / 1ps
module dns_query_builder #(
  parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] name_char,
  input  logic name_last,
  output logic empty,
  input  logic pop,
  output logic [7:0] byte_first,
  output logic [7:0] byte_second,
  output logic second_valid,
  output logic run_last,
  output logic packet_end,
  output logic label_overflow,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [dqb_pkg::ADDR_W-1:0] paddr,
  input  logic [dqb_pkg::DATA_W-1:0] pwdata,
  output logic [dqb_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import dqb_pkg::*;

  localparam int LW = $clog2(MAX_LABEL + 1);
  localparam int PW = $clog2(MAX_LABEL + 19);
  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic id_low_first;
  logic recursion_desired;

  cmd_t front_cmd;
  logic [LW-1:0] front_len;
  logic front_push;
  logic cmd_full;
  logic cmd_empty;
  logic [CMD_W+LW-1:0] cmd_q;
  logic back_pop;
  logic mem_we;
  logic [LW:0] mem_waddr;
  logic [7:0] mem_wdata;
  rel_t release_bank;
  logic [OUT_LW-1:0] out_level;
  logic out_push;
  result_t out_wdata;
  logic [RES_W-1:0] out_rdata;
  result_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_low_first <= 1'b1;
      recursion_desired <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ID_LOW_FIRST: id_low_first <= pwdata[0];
        REG_RECURSION: recursion_desired <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ID_LOW_FIRST: prdata = {{(DATA_W - 1){1'b0}}, id_low_first};
      REG_RECURSION: prdata = {{(DATA_W - 1){1'b0}}, recursion_desired};
    endcase
  end

  dqb_front #(
    .MAX_LABEL(MAX_LABEL),
    .LW(LW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .name_char(name_char),
    .name_last(name_last),
    .full(full),
    .id_low_first(id_low_first),
    .recursion_desired(recursion_desired),
    .cmd_full(cmd_full),
    .cmd_push(front_push),
    .cmd(front_cmd),
    .cmd_len(front_len),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .release_bank(release_bank)
  );

  dqb_fifo #(
    .WIDTH(CMD_W + LW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(front_push),
    .wr_data({front_len, front_cmd}),
    .rd_en(back_pop),
    .rd_data(cmd_q),
    .full(cmd_full),
    .empty(cmd_empty),
    .level()
  );

  dqb_back #(
    .MAX_LABEL(MAX_LABEL),
    .LW(LW),
    .PW(PW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(!cmd_empty),
    .cmd(cmd_t'(cmd_q[CMD_W-1:0])),
    .cmd_len(cmd_q[CMD_W+LW-1:CMD_W]),
    .cmd_pop(back_pop),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .release_bank(release_bank),
    .out_level(out_level),
    .out_push(out_push),
    .out_data(out_wdata)
  );

  dqb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(out_push),
    .wr_data(out_wdata),
    .rd_en(pop),
    .rd_data(out_rdata),
    .full(),
    .empty(empty),
    .level(out_level)
  );

  always_comb begin
    res = result_t'(out_rdata);
    byte_first = res.byte_first;
    byte_second = res.byte_second;
    second_valid = res.second_valid;
    run_last = res.run_last;
    packet_end = res.packet_end;
    label_overflow = res.label_overflow;
  end
endmodule

// File: rtl/dqb_checker.sv
`timescale 1ns / 1ps
module dqb_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [7:0] byte_first,
  input logic [7:0] byte_second,
  input logic second_valid,
  input logic run_last,
  input logic packet_end
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && packet_end) |-> run_last)
    else $error("A packet end arrived on a result that is not the last of its item.");

  a_single_only_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !run_last) |-> second_valid)
    else $error("A result with one byte arrived before the last result of its item.");

  a_unused_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !second_valid) |-> (byte_second == 8'h00))
    else $error("An unused second byte is not zero.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(byte_first) && $stable(byte_second)))
    else $error("A stalled result transaction changed.");

endmodule

bind dns_query_builder dqb_checker u_dqb_checker (
  .clk(clk),
  .rst(rst),
  .empty(empty),
  .pop(pop),
  .byte_first(byte_first),
  .byte_second(byte_second),
  .second_valid(second_valid),
  .run_last(run_last),
  .packet_end(packet_end)
);
